// File: rtl/wrs_pkg.sv
// shared constants, codes and controller/datapath handshake types
package wrs_pkg;

   localparam int MAX_SYMBOLS_DEF = 64;
   localparam int WEIGHT_BITS_DEF = 16;

   localparam int FUNC_W   = 2;
   localparam int WEIGHT_W = 16;
   localparam int TOTAL_W  = 22;
   localparam int IDX_W    = 7;
   localparam int STATUS_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DRAW   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic capture;
      logic decode;
      logic step;
      logic update;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic search_needed;
      logic more;
   } stat_type;

endpackage

// File: rtl/wrs_ram.sv
// generic single write port ram with registered read
module wrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/wrs_ctrl.sv
// sequencing state machine for append, draw and clear
module wrs_ctrl import wrs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_DECODE  = 5'b00010,
      ST_SEARCH  = 5'b00100,
      ST_COMPARE = 5'b01000,
      ST_FINISH  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = stat.search_needed ? ST_SEARCH : ST_FINISH;
         end
         ST_SEARCH: begin
            cmd.step = 1'b1;
            state_in = stat.more ? ST_COMPARE : ST_FINISH;
         end
         ST_COMPARE: begin
            cmd.update = 1'b1;
            state_in   = ST_SEARCH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.publish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/wrs_datapath.sv
// offset table, running total, binary search registers and result register
module wrs_datapath import wrs_pkg::*; #(
   parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [WEIGHT_W-1:0] req_weight_value,
   input  logic [TOTAL_W-1:0]  req_draw_value,
   output logic [IDX_W-1:0]    rsp_symbol_index,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int CW = $clog2(MAX_SYMBOLS + 1);
   localparam int IW = $clog2(MAX_SYMBOLS);
   localparam logic [WEIGHT_W-1:0] WMASK = (WEIGHT_BITS >= WEIGHT_W) ? '1 :
      WEIGHT_W'((33'd1 << WEIGHT_BITS) - 33'd1);

   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   logic [TOTAL_W-1:0]  value_ff, value_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [IW-1:0]       lo_ff, lo_in;
   logic [IW-1:0]       hi_ff, hi_in;
   logic [IW-1:0]       mid_ff, mid_in;
   logic [IDX_W-1:0]    res_index_ff, res_index_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [IDX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                full;
   logic                draw_bad;
   logic [TOTAL_W:0]    sum;
   logic [IW:0]         mid_wide;
   logic [IW:0]         idx_wide;
   logic                ram_we;
   logic [TOTAL_W-1:0]  ram_rd_data;

   assign full     = (count_ff == CW'(MAX_SYMBOLS));
   assign draw_bad = (count_ff == '0) || (value_ff >= total_ff);
   assign sum      = {1'b0, total_ff} + (TOTAL_W + 1)'(weight_ff & WMASK);
   assign mid_wide = ({1'b0, lo_ff} + {1'b0, hi_ff} + (IW + 1)'(1)) >> 1;
   assign idx_wide = {1'b0, lo_ff} + (IW + 1)'(1);

   assign stat.search_needed = (func_ff == FUNC_DRAW) && !draw_bad;
   assign stat.more          = (lo_ff < hi_ff);

   assign ram_we = cmd.decode && (func_ff == FUNC_APPEND) && !full;

   always_comb begin
      func_in       = func_ff;
      weight_in     = weight_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      res_index_in  = res_index_ff;
      res_status_in = res_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;

      if (cmd.capture) begin
         func_in   = req_func;
         weight_in = req_weight_value;
         value_in  = req_draw_value;
      end

      if (cmd.decode) begin
         res_index_in  = '0;
         res_status_in = STATUS_OK;
         case (func_ff)
            FUNC_APPEND: begin
               if (full) begin
                  res_status_in = STATUS_FULL;
               end else begin
                  count_in = count_ff + CW'(1);
                  // saturate the total at its widest value
                  total_in = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
               end
            end
            FUNC_DRAW: begin
               if (draw_bad) begin
                  res_status_in = STATUS_RANGE;
               end else begin
                  lo_in = '0;
                  hi_in = IW'(count_ff - CW'(1));
               end
            end
            FUNC_CLEAR: begin
               count_in = '0;
               total_in = '0;
            end
            default: begin
               res_status_in = STATUS_OK;
            end
         endcase
      end

      if (cmd.step) begin
         if (stat.more) begin
            mid_in = mid_wide[IW-1:0];
         end else begin
            res_index_in = IDX_W'(idx_wide);
         end
      end

      // keep the last symbol whose offset is at or below the value
      if (cmd.update) begin
         if (ram_rd_data <= value_ff) begin
            lo_in = mid_ff;
         end else begin
            hi_in = mid_ff - IW'(1);
         end
      end

      if (cmd.publish) begin
         rsp_index_in  = res_index_ff;
         rsp_status_in = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         total_ff <= '0;
      end else begin
         count_ff <= count_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      weight_ff     <= weight_in;
      value_ff      <= value_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      res_index_ff  <= res_index_in;
      res_status_ff <= res_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
   end

   wrs_ram #(
      .WIDTH (TOTAL_W),
      .DEPTH (MAX_SYMBOLS)
   ) u_offsets (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (total_ff),
      .rd_addr (mid_wide[IW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rsp_symbol_index = rsp_index_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

// File: rtl/weighted_random_select_core.sv
// top level of the weighted random symbol selector
//
//   channel  | dir | ports
//   ---------+-----+---------------------------------------------------------
//   req      | in  | req_valid, req_stall, req_func, req_weight_value,
//            |     | req_draw_value
//   rsp      | out | rsp_valid, rsp_stall, rsp_symbol_index, rsp_status
//
// append, clear and failed draws: captured, then decoded into the result register
// good draw: each halving takes a search step and then a compare step, set by the
// single registered read port of the offset ram
// reset zeroes the symbol count and total; the offset ram is not cleared
// a stalled result holds in the output register while the next item is taken
// and worked through up to its own result
module weighted_random_select_core import wrs_pkg::*; #(
   parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [WEIGHT_W-1:0] req_weight_value,
   input  logic [TOTAL_W-1:0]  req_draw_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [IDX_W-1:0]    rsp_symbol_index,
   output logic [STATUS_W-1:0] rsp_status
);

   cmd_type  cmd;
   stat_type stat;

   wrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   wrs_datapath #(
      .MAX_SYMBOLS (MAX_SYMBOLS),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_func         (req_func),
      .req_weight_value (req_weight_value),
      .req_draw_value   (req_draw_value),
      .rsp_symbol_index (rsp_symbol_index),
      .rsp_status       (rsp_status)
   );

endmodule
